// ===== rtl/pcm_downmix_linear_resampler_unit_defines.svh =====
`ifndef PCM_DOWNMIX_LINEAR_RESAMPLER_UNIT_DEFINES_SVH
`define PCM_DOWNMIX_LINEAR_RESAMPLER_UNIT_DEFINES_SVH

// Assertion helpers; clk and rst come from the scope that uses them.

// Check a consequence in the same cycle as its cause.
`define PDLR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdlr check failed");

// Check a consequence in the cycle after its cause.
`define PDLR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pdlr check failed");

`endif

// ===== rtl/pdlr_pkg.sv =====
package pdlr_pkg;

  // Fixed stream constants
  localparam int OUTPUT_RATE = 16000;
  localparam int MAX_SECONDS = 30;
  localparam int RATE_MIN    = 8000;
  localparam int RATE_MAX    = 48000;
  localparam int MAX_OUT     = 4;
  localparam int MAX_OUTPUTS = OUTPUT_RATE * MAX_SECONDS;

  // Field and state widths
  localparam int RATE_W  = 16;
  localparam int FRAME_W = 21;
  localparam int SENT_W  = 19;
  localparam int REM_W   = 14;
  localparam int PCM_W   = 16;
  localparam int MONO_W  = 17;
  localparam int DIFF_W  = 18;
  localparam int K_W     = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Shared multiplier and interpolation division
  localparam int MUL_W     = 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int U_W       = 31;   // |b-a|*rem fits below 2^31
  localparam int PRE_SHIFT = 7;    // 16000 = 128 * 125
  localparam int RCP_SHIFT = 31;   // floor(y/125) = (y*RECIP) >> 31 for y < 2^24
  localparam int Q_W       = 18;
  localparam int SUM_W     = 19;
  localparam logic [MUL_W-1:0] RECIP = 25'd17179870;

  // Position advance
  localparam int T_W = 17;

  // Output count division
  localparam int DIVN_W = 35;

  // Register indexes
  localparam logic [1:0] REG_RATE   = 2'd0;
  localparam logic [1:0] REG_STEREO = 2'd1;
  localparam logic [1:0] REG_FRAMES = 2'd2;

  // Sequencer states
  typedef enum logic [9:0] {
    S_NMUL   = 10'b0000000001,
    S_NDIV   = 10'b0000000010,
    S_NWAIT  = 10'b0000000100,
    S_IDLE   = 10'b0000001000,
    S_DECIDE = 10'b0000010000,
    S_MUL1   = 10'b0000100000,
    S_MUL2   = 10'b0001000000,
    S_MUL3   = 10'b0010000000,
    S_FIN    = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

endpackage

// ===== rtl/pdlr_div.sv =====
module pdlr_div import pdlr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic [DIVN_W-1:0] quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(DIVN_W);

  logic [DIVN_W-1:0] work;
  logic [RATE_W-1:0] part;
  logic [RATE_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [RATE_W:0]   trial;
  logic [RATE_W:0]   diff;
  logic              fits;

  // One quotient bit per cycle, restoring form
  assign trial = {part, work[DIVN_W-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};
  assign quotient = work;

  // Control: count the bit steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(DIVN_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  // Datapath: shift the dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      part <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      part <= fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      work <= {work[DIVN_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/pcm_downmix_linear_resampler_unit.sv =====
// PCM16 downmix and linear-interpolation resampler to 16 kHz. Each input word is one
// PCM16 frame; it is reduced to mono (left+right in stereo mode, twice left in mono
// mode, units of 2^-16 full scale) and resampled by linear interpolation, with the
// last frame held as the right neighbour. The stream length comes from frame_total and
// input_rate; the last output word carries final_mark. An empty stream, one that
// yields no output or one over 30 s gives one limit_error word per input. An
// interpolated output takes a scheduling decision, three passes through the one
// shared multiplier, a rounding step and the output load; a held last-frame output
// takes the decision and the output load; at most four outputs per input. After
// reset and after every register write the output count is rebuilt by a bit-serial
// divider, during which in_ready is low.
module pcm_downmix_linear_resampler_unit import pdlr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [PCM_W-1:0]  left_sample,
  input  logic signed [PCM_W-1:0]  right_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [MONO_W-1:0] out_sample,
  output logic                     final_mark,
  output logic                     limit_error,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  localparam logic [T_W-1:0] OR1 = T_W'(OUTPUT_RATE);
  localparam logic [T_W-1:0] OR2 = T_W'(2 * OUTPUT_RATE);
  localparam logic [T_W-1:0] OR3 = T_W'(3 * OUTPUT_RATE);

  state_t state;

  // Configuration registers
  logic [RATE_W-1:0]  input_rate;
  logic               stereo_mode;
  logic [FRAME_W-1:0] frame_total;
  logic               cfg_wr;

  // Stream constants rebuilt after each write
  logic [RATE_W-1:0]  rate_c;
  logic [FRAME_W-1:0] lim_frames;
  logic [SENT_W-1:0]  n_total;
  logic               reject;

  // Stream state
  logic signed [MONO_W-1:0] prev_mono;
  logic [FRAME_W-1:0]       frames_seen;
  logic [SENT_W-1:0]        sent;
  logic [FRAME_W-1:0]       pos_whole;
  logic [REM_W-1:0]         pos_rem;

  // Per-item work registers
  logic signed [MONO_W-1:0] cur_mono;
  logic signed [MONO_W-1:0] res_sample;
  logic                     res_err;
  logic [K_W-1:0]           k_cnt;
  logic [U_W-1:0]           u_reg;
  logic [Q_W-1:0]           qf;

  // Shared multiplier
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;

  // Divider hookup
  logic              div_start;
  logic [DIVN_W-1:0] div_dividend;
  logic [DIVN_W-1:0] div_q;
  logic              div_done;

  // Combinational helpers
  logic signed [MONO_W-1:0] mono_in;
  logic signed [DIFF_W-1:0] diff;
  logic                     diff_neg;
  logic [DIFF_W-1:0]        diff_abs;
  logic [T_W-1:0]           t_sum;
  logic [1:0]               carry;
  logic [REM_W-1:0]         rem_next;
  logic                     room;
  logic                     interp_due;
  logic                     hold_due;
  logic                     last_frame;
  logic                     is_final;
  logic                     r_nz;
  logic [SUM_W-1:0]         q_mag;
  logic [SUM_W-1:0]         q_sgn;
  logic [SUM_W-1:0]         sum_ext;
  logic                     div_reject;
  logic                     out_load;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign in_ready = (state == S_IDLE);

  // Clamp the rate to the supported range
  always_comb begin
    if (input_rate < RATE_W'(RATE_MIN)) begin
      rate_c = RATE_W'(RATE_MIN);
    end else if (input_rate > RATE_W'(RATE_MAX)) begin
      rate_c = RATE_W'(RATE_MAX);
    end else begin
      rate_c = input_rate;
    end
  end

  assign lim_frames = FRAME_W'(rate_c) * FRAME_W'(MAX_SECONDS);

  // Register read
  always_comb begin
    case (paddr[3:2])
      REG_RATE:   prdata = DATA_W'(input_rate);
      REG_STEREO: prdata = DATA_W'(stereo_mode);
      REG_FRAMES: prdata = DATA_W'(frame_total);
      default:    prdata = '0;
    endcase
  end

  // Downmix
  always_comb begin
    if (stereo_mode) begin
      mono_in = MONO_W'(left_sample) + MONO_W'(right_sample);
    end else begin
      mono_in = {left_sample, 1'b0};
    end
  end

  // Neighbour difference as sign and magnitude
  assign diff     = DIFF_W'(cur_mono) - DIFF_W'(prev_mono);
  assign diff_neg = diff[DIFF_W-1];
  assign diff_abs = diff_neg ? (DIFF_W'(0) - diff) : diff;

  // Advance the output position by rate/16000
  assign t_sum = T_W'(pos_rem) + T_W'(rate_c);
  always_comb begin
    if (t_sum >= OR3) begin
      carry    = 2'd3;
      rem_next = REM_W'(t_sum - OR3);
    end else if (t_sum >= OR2) begin
      carry    = 2'd2;
      rem_next = REM_W'(t_sum - OR2);
    end else if (t_sum >= OR1) begin
      carry    = 2'd1;
      rem_next = REM_W'(t_sum - OR1);
    end else begin
      carry    = 2'd0;
      rem_next = t_sum[REM_W-1:0];
    end
  end

  // Output scheduling tests
  assign room       = (k_cnt < K_W'(MAX_OUT)) && (sent < n_total);
  assign interp_due = (frames_seen != '0) && room && (pos_whole < frames_seen);
  assign last_frame = ({1'b0, frames_seen} + (FRAME_W + 1)'(1)) == {1'b0, frame_total};
  assign hold_due   = last_frame && room;
  assign is_final   = ({1'b0, sent} + (SENT_W + 1)'(1)) == {1'b0, n_total};

  // Floor toward minus infinity: bump the magnitude on a negative inexact quotient
  assign r_nz    = prod[U_W-1:0] != u_reg;
  assign q_mag   = SUM_W'(qf) + SUM_W'(r_nz && diff_neg);
  assign q_sgn   = diff_neg ? (SUM_W'(0) - q_mag) : q_mag;
  assign sum_ext = SUM_W'(prev_mono) + q_sgn;

  // Shared multiplier operands
  always_comb begin
    case (state)
      S_NMUL: begin
        mul_a = MUL_W'(frame_total);
        mul_b = MUL_W'(OUTPUT_RATE);
      end
      S_MUL1: begin
        mul_a = MUL_W'(diff_abs[MONO_W-1:0]);
        mul_b = MUL_W'(pos_rem);
      end
      S_MUL2: begin
        mul_a = MUL_W'(prod[U_W-1:PRE_SHIFT]);
        mul_b = RECIP;
      end
      S_MUL3: begin
        mul_a = MUL_W'(prod[RCP_SHIFT+Q_W-1:RCP_SHIFT]);
        mul_b = MUL_W'(OUTPUT_RATE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};
  end

  // Output count: round(frame_total*16000/rate)
  assign div_start    = (state == S_NDIV);
  assign div_dividend = prod[DIVN_W-1:0] + DIVN_W'(rate_c >> 1);
  assign div_reject   = (frame_total == '0) || (frame_total > lim_frames) ||
                        (div_q == '0) || (div_q > DIVN_W'(MAX_OUTPUTS));

  pdlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (rate_c),
    .quotient (div_q),
    .done     (div_done)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      input_rate  <= RATE_W'(OUTPUT_RATE);
      stereo_mode <= 1'b0;
      frame_total <= FRAME_W'(1);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RATE:   input_rate  <= pwdata[RATE_W-1:0];
        REG_STEREO: stereo_mode <= pwdata[0];
        REG_FRAMES: frame_total <= pwdata[FRAME_W-1:0];
        default:    ;
      endcase
    end
  end

  // Load the output word when the register is free and no register write arrives, drop it once taken
  assign out_load = (state == S_EMIT) && !cfg_wr && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_NMUL;
      n_total     <= '0;
      reject      <= 1'b1;
      prev_mono   <= '0;
      frames_seen <= '0;
      sent        <= '0;
      pos_whole   <= '0;
      pos_rem     <= '0;
      k_cnt       <= '0;
    end else begin
      if (cfg_wr) begin
        state <= S_NMUL;
      end else begin
        case (state)
          S_NMUL: state <= S_NDIV;
          S_NDIV: state <= S_NWAIT;
          S_NWAIT: begin
            if (div_done) begin
              n_total <= div_q[SENT_W-1:0];
              reject  <= div_reject;
              state   <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              cur_mono <= mono_in;
              k_cnt    <= '0;
              state    <= S_DECIDE;
            end
          end
          S_DECIDE: begin
            if (reject) begin
              res_sample <= '0;
              res_err    <= 1'b1;
              state      <= S_EMIT;
            end else if (frames_seen >= frame_total) begin
              state <= S_IDLE;
            end else if (interp_due) begin
              state <= S_MUL1;
            end else if (hold_due) begin
              res_sample <= cur_mono;
              res_err    <= 1'b0;
              state      <= S_EMIT;
            end else begin
              prev_mono   <= cur_mono;
              frames_seen <= frames_seen + FRAME_W'(1);
              state       <= S_IDLE;
            end
          end
          S_MUL1: state <= S_MUL2;
          S_MUL2: begin
            u_reg <= prod[U_W-1:0];
            state <= S_MUL3;
          end
          S_MUL3: begin
            qf    <= prod[RCP_SHIFT+Q_W-1:RCP_SHIFT];
            state <= S_FIN;
          end
          S_FIN: begin
            res_sample <= sum_ext[MONO_W-1:0];
            res_err    <= 1'b0;
            state      <= S_EMIT;
          end
          S_EMIT: begin
            // Hold until the output register is free
            if (!out_valid || out_ready) begin
              out_sample  <= res_sample;
              final_mark  <= !res_err && is_final;
              limit_error <= res_err;
              if (res_err) begin
                state <= S_IDLE;
              end else begin
                sent      <= sent + SENT_W'(1);
                k_cnt     <= k_cnt + K_W'(1);
                pos_whole <= pos_whole + FRAME_W'(carry);
                pos_rem   <= rem_next;
                state     <= S_DECIDE;
              end
            end
          end
          default: state <= S_NMUL;
        endcase
      end
    end
  end

endmodule

// ===== rtl/pdlr_checker.sv =====
`include "pcm_downmix_linear_resampler_unit_defines.svh"

module pdlr_checker import pdlr_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [MONO_W-1:0] out_sample,
  input logic                     final_mark,
  input logic                     limit_error,
  input logic                     psel,
  input logic                     penable,
  input logic                     pwrite,
  input logic                     pready
);

  // A stalled output word holds
  `PDLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(final_mark) && $stable(limit_error))

  // An error word carries no sample and no end mark
  `PDLR_ASSERT_SAME(a_err_clean, out_valid && limit_error, out_sample == '0 && !final_mark)

  // The sequencer is busy right after taking a word
  `PDLR_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

  // A register write restarts the output count rebuild
  `PDLR_ASSERT_NEXT(a_busy_after_cfg, psel && penable && pwrite && pready, !in_ready)

endmodule

bind pcm_downmix_linear_resampler_unit pdlr_checker u_pdlr_checker (.*);
